@@ hdl/rse_pkg.sv @@
// Shared types, constants and codes for the rANS symbol encoder.
package rse_pkg;

    localparam int SCALE_BITS_DEF   = 14;
    localparam int SYMBOL_COUNT_DEF = 256;

    localparam logic [63:0] LOWER_BOUND = 64'h0000_0000_8000_0000;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ENCODE = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [1:0] OSEL_ZERO = 2'd0;
    localparam logic [1:0] OSEL_LOW  = 2'd1;
    localparam logic [1:0] OSEL_HIGH = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  symbol;
        logic [14:0] start_value;
        logic [14:0] freq_value;
    } in_item_t;

    typedef struct packed {
        logic [31:0] code_word;
        logic        last;
        logic        bad_symbol;
    } out_item_t;

    typedef struct packed {
        logic       load_we;
        logic       capture;
        logic       div_start;
        logic       div_shift;
        logic       div_step;
        logic       commit;
        logic       flush_reset;
        logic       push;
        logic [1:0] out_sel;
        logic       last;
        logic       bad;
    } cmd_t;

    typedef struct packed {
        logic table_ok;
        logic renorm;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

@@ hdl/rans_symbol_encoder_top.sv @@
// Top level of the rANS symbol encoder (64-bit state, 32-bit renormalization).
// Load or mode three: no result. Zero-frequency encode and flush each produce output words.
// Encode: next item accepted after the table read, check, 64-step bit-serial divide
//   and state update; a renormalization word, when needed, goes out before the divide.
// Results leave through one output register; a stalled output holds the sequencer while it has a word to push.
// Reset (rst_n, async low): state = 2^31, all table entries marked unloaded (encode gives a bad symbol).
module rans_symbol_encoder_top
#(
    parameter int SCALE_BITS   = rse_pkg::SCALE_BITS_DEF,
    parameter int SYMBOL_COUNT = rse_pkg::SYMBOL_COUNT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rse_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output rse_pkg::out_item_t out_data
);

    rse_pkg::cmd_t    cmd;
    rse_pkg::status_t status;

    // sequencer: one input transfer at a time, drives datapath commands
    rse_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (in_data.mode),
        .status   (status),
        .cmd      (cmd)
    );

    // tables, coder state, divider and output register
    rse_datapath
    #(
        .SCALE_BITS   (SCALE_BITS),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

@@ hdl/rse_ctrl.sv @@
// Sequencer for the rANS encoder: decodes items and steps the datapath.
module rse_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        mode,
    input  rse_pkg::status_t  status,
    output rse_pkg::cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOOK   = 3'd1;
    localparam logic [2:0] ST_BAD    = 3'd2;
    localparam logic [2:0] ST_RENORM = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_COMMIT = 3'd5;
    localparam logic [2:0] ST_FLO    = 3'd6;
    localparam logic [2:0] ST_FHI    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        rse_pkg::MODE_LOAD:
                        begin
                            cmd.load_we = 1'b1;
                        end
                        rse_pkg::MODE_ENCODE:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = ST_LOOK;
                        end
                        rse_pkg::MODE_FLUSH:
                        begin
                            state_next = ST_FLO;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOOK:
            begin
                if (!status.table_ok)
                begin
                    state_next = ST_BAD;
                end
                else if (status.renorm)
                begin
                    state_next = ST_RENORM;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_BAD:
            begin
                if (status.out_free)
                begin
                    cmd.push    = 1'b1;
                    cmd.out_sel = rse_pkg::OSEL_ZERO;
                    cmd.last    = 1'b1;
                    cmd.bad     = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_RENORM:
            begin
                if (status.out_free)
                begin
                    cmd.push      = 1'b1;
                    cmd.out_sel   = rse_pkg::OSEL_LOW;
                    cmd.last      = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_shift = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FLO:
            begin
                if (status.out_free)
                begin
                    cmd.push    = 1'b1;
                    cmd.out_sel = rse_pkg::OSEL_LOW;
                    state_next  = ST_FHI;
                end
            end
            ST_FHI:
            begin
                if (status.out_free)
                begin
                    cmd.push        = 1'b1;
                    cmd.out_sel     = rse_pkg::OSEL_HIGH;
                    cmd.last        = 1'b1;
                    cmd.flush_reset = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/rse_datapath.sv @@
// Datapath: symbol tables, coder state, bit-serial divider, output register.
module rse_datapath
#(
    parameter int SCALE_BITS   = rse_pkg::SCALE_BITS_DEF,
    parameter int SYMBOL_COUNT = rse_pkg::SYMBOL_COUNT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  rse_pkg::in_item_t  in_data,
    input  rse_pkg::cmd_t      cmd,
    output rse_pkg::status_t   status,
    output logic               out_valid,
    input  logic               out_stall,
    output rse_pkg::out_item_t out_data
);

    localparam int IDX_W        = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int RENORM_SHIFT = 63 - SCALE_BITS;

    logic [14:0]             start_mem [SYMBOL_COUNT];
    logic [14:0]             freq_mem  [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] valid_reg;

    logic [14:0] start_rd_reg;
    logic [14:0] freq_rd_reg;
    logic        hit_rd_reg;
    logic [63:0] coder_reg;
    logic [63:0] dq_reg;
    logic [14:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        out_valid_reg;
    rse_pkg::out_item_t out_data_reg;

    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic [15:0]      rem_sh;
    logic             ge;
    logic [15:0]      rem_sub;
    logic [31:0]      word_sel;

    assign in_range = ({1'b0, in_data.symbol} < 9'(SYMBOL_COUNT));
    assign idx      = in_data.symbol[IDX_W-1:0];

    // one restoring-division step per cycle
    assign rem_sh  = {rem_reg, dq_reg[63]};
    assign ge      = (rem_sh >= {1'b0, freq_rd_reg});
    assign rem_sub = rem_sh - {1'b0, freq_rd_reg};

    assign status.table_ok = hit_rd_reg && (freq_rd_reg != 15'd0);
    assign status.renorm   = ((coder_reg >> RENORM_SHIFT) >= {49'd0, freq_rd_reg});
    assign status.div_last = (cnt_reg == 6'd0);
    assign status.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        case (cmd.out_sel)
            rse_pkg::OSEL_LOW:  word_sel = coder_reg[31:0];
            rse_pkg::OSEL_HIGH: word_sel = coder_reg[63:32];
            default:            word_sel = 32'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_we && in_range)
        begin
            start_mem[idx] <= in_data.start_value;
            freq_mem[idx]  <= in_data.freq_value;
        end
        if (cmd.capture)
        begin
            start_rd_reg <= start_mem[idx];
            freq_rd_reg  <= freq_mem[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            hit_rd_reg    <= 1'b0;
            coder_reg     <= rse_pkg::LOWER_BOUND;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_we && in_range)
            begin
                valid_reg[idx] <= 1'b1;
            end
            if (cmd.capture)
            begin
                hit_rd_reg <= in_range && valid_reg[idx];
            end
            if (cmd.commit)
            begin
                coder_reg <= (dq_reg << SCALE_BITS) + {49'd0, start_rd_reg}
                             + {49'd0, rem_reg};
            end
            else if (cmd.flush_reset)
            begin
                coder_reg <= rse_pkg::LOWER_BOUND;
            end
            if (cmd.div_start)
            begin
                cnt_reg <= 6'd63;
            end
            else if (cmd.div_step && cnt_reg != 6'd0)
            begin
                cnt_reg <= cnt_reg - 6'd1;
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dq_reg  <= cmd.div_shift ? {32'd0, coder_reg[63:32]} : coder_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dq_reg  <= {dq_reg[62:0], ge};
            rem_reg <= ge ? rem_sub[14:0] : rem_sh[14:0];
        end
        if (cmd.push)
        begin
            out_data_reg.code_word  <= word_sel;
            out_data_reg.last       <= cmd.last;
            out_data_reg.bad_symbol <= cmd.bad;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ hdl/rse_checker.sv @@
// Port-level checks for the rANS symbol encoder, bound to the top level.
module rse_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input rse_pkg::out_item_t out_data,
    input logic               out_valid,
    input logic               out_stall
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output changed");

    a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.bad_symbol |-> out_data.last && out_data.code_word == 32'd0)
        else $error("bad symbol result malformed");

    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_stall, out_valid}))
        else $error("handshake output unknown");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !out_valid && !in_stall)
        else $error("not idle in reset");

endmodule

bind rans_symbol_encoder_top rse_checker u_rse_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall)
);

@@ tb/tb_rans_symbol_encoder_top.sv @@
// Testbench for the rANS symbol encoder: directed and random loads, encodes and flushes.
module tb_rans_symbol_encoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PB       = rse_pkg::SCALE_BITS_DEF;
    localparam int NSYM     = rse_pkg::SYMBOL_COUNT_DEF;
    localparam int IDLE_MAX = 20000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    rse_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_stall;
    rse_pkg::out_item_t out_data;

    // Predictor state: coder register and symbol tables.
    logic [63:0] pred_state;
    logic [14:0] pred_freq [NSYM];
    logic [14:0] pred_start [NSYM];

    rse_pkg::out_item_t expected_words[$];
    int        errors;
    int        words_seen;
    int        encodes_sent;
    int        renorms_seen;
    int        idle_cycles;
    logic      stall_enable;

    rans_symbol_encoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Predict the words that one accepted transfer produces.
    task automatic predict_item(input rse_pkg::in_item_t it);
        logic [63:0] x;
        logic [63:0] f;
        logic [63:0] q;
        logic [63:0] r;
        rse_pkg::out_item_t w;
        begin
            case (it.mode)
                rse_pkg::MODE_LOAD:
                begin
                    pred_start[it.symbol] = it.start_value;
                    pred_freq[it.symbol]  = it.freq_value;
                end
                rse_pkg::MODE_ENCODE:
                begin
                    if (pred_freq[it.symbol] == 15'd0)
                    begin
                        w.code_word  = 32'd0;
                        w.last       = 1'b1;
                        w.bad_symbol = 1'b1;
                        expected_words.insert(expected_words.size(), w);
                    end
                    else
                    begin
                        x = pred_state;
                        f = {49'd0, pred_freq[it.symbol]};
                        // exact renormalization test, never overflows
                        if ((x >> (63 - PB)) >= f)
                        begin
                            w.code_word  = x[31:0];
                            w.last       = 1'b1;
                            w.bad_symbol = 1'b0;
                            expected_words.insert(expected_words.size(), w);
                            renorms_seen++;
                            x = x >> 32;
                        end
                        q = x / f;
                        r = x % f;
                        pred_state = (q << PB) + {49'd0, pred_start[it.symbol]} + r;
                    end
                end
                rse_pkg::MODE_FLUSH:
                begin
                    w.code_word  = pred_state[31:0];
                    w.last       = 1'b0;
                    w.bad_symbol = 1'b0;
                    expected_words.insert(expected_words.size(), w);
                    w.code_word  = pred_state[63:32];
                    w.last       = 1'b1;
                    expected_words.insert(expected_words.size(), w);
                    pred_state = rse_pkg::LOWER_BOUND;
                end
                default: ;  // mode three does nothing
            endcase
        end
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int p;
        begin
            p = $urandom_range(0, 99);
            if (p < 55)
                gap_len = 0;
            else if (p < 93)
                gap_len = $urandom_range(1, 3);
            else
                gap_len = $urandom_range(10, 90);
        end
    endfunction

    // Send one transfer; prediction happens at the accepting edge.
    task automatic send_item(input rse_pkg::in_item_t it, input bit with_gaps);
        int g;
        begin
            if (with_gaps)
            begin
                g = gap_len();
                if (g > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (g) @(posedge clk);
                end
            end
            in_valid <= 1'b1;
            in_data  <= it;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            predict_item(it);
            if (it.mode == rse_pkg::MODE_ENCODE)
                encodes_sent++;
        end
    endtask

    function automatic rse_pkg::in_item_t make_item(logic [1:0] m, logic [7:0] s,
                                                    logic [14:0] st, logic [14:0] fr);
        rse_pkg::in_item_t it;
        begin
            it.mode        = m;
            it.symbol      = s;
            it.start_value = st;
            it.freq_value  = fr;
            make_item      = it;
        end
    endfunction

    // Receiver stall generator.
    initial
    begin
        int g;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!stall_enable)
                out_stall <= 1'b0;
            else
            begin
                g = gap_len();
                if (g == 0)
                    out_stall <= 1'b0;
                else
                begin
                    out_stall <= 1'b1;
                    repeat (g) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // Result checker: every accepted word against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            words_seen++;
            if (expected_words.size() == 0)
            begin
                $error("unexpected word %h last %b bad %b",
                       out_data.code_word, out_data.last, out_data.bad_symbol);
                errors++;
            end
            else
            begin
                rse_pkg::out_item_t e;
                e = expected_words.pop_front();
                if (out_data.code_word !== e.code_word)
                begin
                    $error("code_word expected %h actual %h", e.code_word, out_data.code_word);
                    errors++;
                end
                if (out_data.last !== e.last)
                begin
                    $error("last expected %b actual %b", e.last, out_data.last);
                    errors++;
                end
                if (out_data.bad_symbol !== e.bad_symbol)
                begin
                    $error("bad_symbol expected %b actual %b", e.bad_symbol,
                           out_data.bad_symbol);
                    errors++;
                end
            end
        end
    end

    // Watchdog: cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        begin
            in_valid <= 1'b0;
            while (expected_words.size() != 0)
                @(posedge clk);
            // an encode that emits nothing may still be in its divide loop
            repeat (80) @(posedge clk);
        end
    endtask

    // Extremes of the fields, empty tables, all modes.
    task automatic test_directed();
        begin
            send_item(make_item(rse_pkg::MODE_ENCODE, 8'd0, 15'd0, 15'd0), 0);  // empty table
            send_item(make_item(rse_pkg::MODE_FLUSH, 8'd0, 15'd0, 15'd0), 0);   // reset state
            send_item(make_item(rse_pkg::MODE_NONE, 8'hFF, 15'h7FFF, 15'h7FFF), 0);
            send_item(make_item(rse_pkg::MODE_LOAD, 8'd0, 15'd0, 15'd1), 0);
            send_item(make_item(rse_pkg::MODE_LOAD, 8'd255, 15'd16383, 15'd1), 0);
            send_item(make_item(rse_pkg::MODE_LOAD, 8'd17, 15'd100, 15'd16384), 0);
            // inconsistent entry
            send_item(make_item(rse_pkg::MODE_LOAD, 8'd200, 15'h7FFF, 15'h7FFF), 0);
            // freq 1 grows the state fast: renormalization on repeated encodes
            repeat (4) send_item(make_item(rse_pkg::MODE_ENCODE, 8'd0, 15'd0, 15'd0), 0);
            send_item(make_item(rse_pkg::MODE_ENCODE, 8'd255, 15'd0, 15'd0), 0);
            send_item(make_item(rse_pkg::MODE_ENCODE, 8'd17, 15'd0, 15'd0), 0);
            send_item(make_item(rse_pkg::MODE_ENCODE, 8'd200, 15'd0, 15'd0), 0);
            send_item(make_item(rse_pkg::MODE_FLUSH, 8'd0, 15'd0, 15'd0), 0);
            send_item(make_item(rse_pkg::MODE_ENCODE, 8'd200, 15'd0, 15'd0), 0);
            send_item(make_item(rse_pkg::MODE_ENCODE, 8'd200, 15'd0, 15'd0), 0);
            send_item(make_item(rse_pkg::MODE_ENCODE, 8'd99, 15'd0, 15'd0), 0);  // never loaded
            send_item(make_item(rse_pkg::MODE_LOAD, 8'd0, 15'd0, 15'd0), 0);     // clear entry
            send_item(make_item(rse_pkg::MODE_ENCODE, 8'd0, 15'd0, 15'd0), 0);
            send_item(make_item(rse_pkg::MODE_FLUSH, 8'd0, 15'd0, 15'd0), 0);
            wait_drained();
        end
    endtask

    // Random well-formed tables with random message encodes, plus noise.
    task automatic test_random(input int count);
        int          n;
        int          p;
        int          sym;
        logic [14:0] fr;
        begin
            n = 0;
            while (n < count)
            begin
                p = $urandom_range(0, 99);
                sym = $urandom_range(0, NSYM - 1);
                if (p < 12)
                begin
                    // consistent entry mostly, sometimes wild
                    if ($urandom_range(0, 3) != 0)
                    begin
                        fr = 15'($urandom_range(1, 1 << $urandom_range(0, PB)));
                        if (fr > 15'(1 << PB))
                            fr = 15'(1 << PB);
                        send_item(make_item(rse_pkg::MODE_LOAD, 8'(sym),
                                  15'($urandom_range(0, (1 << PB) - fr)), fr), 1);
                    end
                    else
                        send_item(make_item(rse_pkg::MODE_LOAD, 8'(sym), 15'($urandom),
                                  15'($urandom)), 1);
                end
                else if (p < 92)
                    send_item(make_item(rse_pkg::MODE_ENCODE, 8'(sym), 15'($urandom),
                              15'($urandom)), 1);
                else if (p < 97)
                    send_item(make_item(rse_pkg::MODE_FLUSH, 8'(sym), 15'($urandom),
                              15'($urandom)), 1);
                else
                    send_item(make_item(rse_pkg::MODE_NONE, 8'(sym), 15'($urandom),
                              15'($urandom)), 1);
                if (p < 97)
                    n++;
            end
            wait_drained();
        end
    endtask

    initial
    begin
        errors       = 0;
        words_seen   = 0;
        encodes_sent = 0;
        renorms_seen = 0;
        idle_cycles  = 0;
        stall_enable = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        pred_state   = rse_pkg::LOWER_BOUND;
        for (int i = 0; i < NSYM; i++)
        begin
            pred_freq[i]  = 15'd0;
            pred_start[i] = 15'd0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        stall_enable = 1'b1;
        test_random(1820);

        $display("Covered %0d encodes (%0d renormalizations), %0d words checked.",
                 encodes_sent, renorms_seen, words_seen);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
